// File: rtl/tors_pkg.sv
package tors_pkg;

  localparam int unsigned MIN_W       = 11;
  localparam int unsigned SLOT_IDX_W  = 4;
  localparam logic [MIN_W-1:0] DAY_MINUTES = MIN_W'(1440);

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_MANUAL = 2'd2,
    MODE_NONE   = 2'd3
  } tors_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_REPORT
  } tors_state_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [SLOT_IDX_W-1:0] slot;
    logic [MIN_W-1:0]      minute;
    logic [MIN_W-1:0]      off_minute;
    logic                  on_enable;
    logic                  off_enable;
    logic                  repeat_enable;
    logic                  relay_cmd;
  } tors_in_t;

  typedef struct packed {
    logic relay_on;
    logic changed;
  } tors_out_t;

  typedef struct packed {
    logic off_en;
    logic on_en;
    logic rpt_en;
  } tors_en_t;

  typedef struct packed {
    logic [MIN_W-1:0] on_time;
    logic [MIN_W-1:0] off_time;
    tors_en_t         en;
  } tors_slot_t;

  // Write port of the slot table
  typedef struct packed {
    logic [SLOT_IDX_W-1:0] idx;
    logic                  on_we;
    logic                  off_we;
    logic                  en_we;
    logic [MIN_W-1:0]      on_time;
    logic [MIN_W-1:0]      off_time;
    tors_en_t              en;
  } tors_wr_t;

endpackage

// File: rtl/tors_slot_table.sv
module tors_slot_table #(
  parameter int unsigned SLOT_COUNT = 4,
  parameter int unsigned IDX_W      = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  tors_pkg::tors_wr_t  wr,
  input  logic [IDX_W-1:0]    rd_idx,
  output tors_pkg::tors_slot_t rd_slot
);
  import tors_pkg::*;

  tors_slot_t slots [SLOT_COUNT];
  logic [IDX_W-1:0] wr_idx;

  assign wr_idx  = wr.idx[IDX_W-1:0];
  assign rd_slot = slots[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots[i] <= '0;
      end
    end else begin
      if (wr.on_we) begin
        slots[wr_idx].on_time <= wr.on_time;
      end
      if (wr.off_we) begin
        slots[wr_idx].off_time <= wr.off_time;
      end
      if (wr.en_we) begin
        slots[wr_idx].en <= wr.en;
      end
    end
  end

endmodule

// File: rtl/tors_ctrl.sv
module tors_ctrl #(
  parameter int unsigned SLOT_COUNT = 4,
  parameter int unsigned IDX_W      = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  tors_pkg::tors_in_t   req,
  output logic                 busy,
  output logic                 done,
  output tors_pkg::tors_out_t  rsp,
  output tors_pkg::tors_wr_t   wr,
  output logic [IDX_W-1:0]     rd_idx,
  input  tors_pkg::tors_slot_t rd_slot
);
  import tors_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);
  localparam logic [SLOT_IDX_W:0] SLOT_LIMIT = (SLOT_IDX_W + 1)'(SLOT_COUNT);

  tors_state_t state, state_next;
  tors_in_t    item;
  logic [IDX_W-1:0] idx;
  logic        relay;
  logic        relay_next;
  logic        pending;
  logic        pending_next;
  tors_mode_t  mode;
  logic        slot_ok;

  // per-slot evaluation during a tick
  logic     hit_on, hit_off, mid_relay, mid_off, chg_relay, chg_en;
  tors_en_t en_new;

  assign mode    = tors_mode_t'(item.mode);
  assign slot_ok = {1'b0, item.slot} < SLOT_LIMIT;
  assign rd_idx  = idx;

  always_comb begin
    hit_on    = rd_slot.en.on_en && (rd_slot.on_time == item.minute);
    mid_relay = hit_on ? 1'b1 : relay;
    mid_off   = (hit_on && !rd_slot.en.rpt_en) ? 1'b1 : rd_slot.en.off_en;
    hit_off   = mid_off && (rd_slot.off_time == item.minute);
    en_new        = rd_slot.en;
    en_new.off_en = (hit_off && !rd_slot.en.rpt_en) ? 1'b0 : mid_off;
    chg_relay = (hit_on && !relay) || (hit_off && mid_relay);
    chg_en    = (mid_off != rd_slot.en.off_en) ||
                (hit_off && !rd_slot.en.rpt_en && mid_off);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (tors_mode_t'(req.mode) == MODE_TICK) ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = ST_REPORT;
        end
      end
      ST_APPLY:  state_next = ST_REPORT;
      ST_REPORT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != ST_IDLE);
    done         = (state == ST_REPORT);
    rsp.relay_on = relay;
    rsp.changed  = pending;
    relay_next   = relay;
    pending_next = pending;
    wr           = '0;
    wr.idx       = item.slot;
    unique case (state)
      ST_SCAN: begin
        wr.idx     = SLOT_IDX_W'(idx);
        wr.en_we   = 1'b1;
        wr.en      = en_new;
        relay_next = hit_off ? 1'b0 : mid_relay;
        if (chg_relay || chg_en) begin
          pending_next = 1'b1;
        end
      end
      ST_APPLY: begin
        priority if (mode == MODE_WRITE && slot_ok) begin
          wr.on_we    = item.minute < DAY_MINUTES;
          wr.off_we   = item.off_minute < DAY_MINUTES;
          wr.en_we    = 1'b1;
          wr.on_time  = item.minute;
          wr.off_time = item.off_minute;
          wr.en       = '{off_en: item.off_enable, on_en: item.on_enable,
                          rpt_en: item.repeat_enable};
          if (wr.on_we || wr.off_we || (wr.en != rd_slot.en)) begin
            pending_next = 1'b1;
          end
        end else if (mode == MODE_MANUAL) begin
          relay_next = item.relay_cmd;
          if (item.relay_cmd != relay) begin
            pending_next = 1'b1;
          end
        end else begin
        end
      end
      ST_REPORT: begin
        // report the flag, then drop it after a tick
        if (mode == MODE_TICK) begin
          pending_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      relay   <= 1'b0;
      pending <= 1'b0;
      idx     <= '0;
    end else begin
      state   <= state_next;
      relay   <= relay_next;
      pending <= pending_next;
      if (state == ST_IDLE) begin
        // point the read port at slot 0 for a tick, or at the addressed slot otherwise
        idx <= (tors_mode_t'(req.mode) == MODE_TICK) ? '0 : req.slot[IDX_W-1:0];
      end else if (state == ST_SCAN && idx != LAST_IDX) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      item <= req;
    end
  end

endmodule

// File: rtl/time_of_day_relay_scheduler.sv
// Channel   Handshake              Payload
// request   start / busy           req  (tors_in_t)
// result    done (one-cycle pulse) rsp  (tors_out_t)
//
// A transaction is taken when start is high and busy is low; busy then stays high.
// A tick visits one slot per cycle with one match unit, then reports.
// Any other request passes through the apply state, then the report state.
// The result is shown for one cycle on done; the receiver cannot stall it.
// Synchronous reset clears the relay, the pending flag and every slot.
module time_of_day_relay_scheduler #(
  parameter int unsigned SLOT_COUNT = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  tors_pkg::tors_in_t  req,
  output logic                busy,
  output logic                done,
  output tors_pkg::tors_out_t rsp
);
  import tors_pkg::*;

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  tors_wr_t         wr;
  logic [IDX_W-1:0] rd_idx;
  tors_slot_t       rd_slot;

  tors_slot_table #(
    .SLOT_COUNT(SLOT_COUNT),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd_slot(rd_slot)
  );

  tors_ctrl #(
    .SLOT_COUNT(SLOT_COUNT),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .busy   (busy),
    .done   (done),
    .rsp    (rsp),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd_slot(rd_slot)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_in_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside a transaction");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe not followed by idle");

  a_table_write_busy: assert property (@(posedge clk) disable iff (rst)
    (wr.on_we || wr.off_we || wr.en_we) |-> (busy && !done))
    else $error("slot table written outside the work phase");

endmodule

// File: test/time_of_day_relay_scheduler_tb.sv
`timescale 1ns / 100ps

module time_of_day_relay_scheduler_tb;
  import tors_pkg::*;

  localparam int SLOTS = 4;
  localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RANDOM_ITEMS = 1650;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  tors_in_t  req = '0;
  logic      busy;
  logic      done;
  tors_out_t rsp;

  time_of_day_relay_scheduler #(
    .SLOT_COUNT(SLOTS)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    tors_in_t  it;
    bit        known;
    tors_out_t want;
  } row_t;

  // Scheduler image kept by the testbench
  logic             relay_now = 1'b0;
  logic             change_flag = 1'b0;
  logic [MIN_W-1:0] on_min [SLOTS];
  logic [MIN_W-1:0] off_min [SLOTS];
  tors_en_t         slot_en [SLOTS];

  tors_out_t relay_results_due[$];
  int        fails = 0;
  int        minute_pool[8];

  function automatic void relay_to(logic v);
    if (relay_now != v) begin
      relay_now = v;
      change_flag = 1'b1;
    end
  endfunction

  function automatic tors_out_t relay_step(tors_in_t it);
    tors_out_t r;
    tors_en_t  e;
    logic [SLOT_BITS-1:0] si;
    r = '0;
    si = it.slot[SLOT_BITS-1:0];
    if (it.mode == MODE_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        // on event first, so equal on and off minutes give on then off
        if (slot_en[i].on_en && on_min[i] == it.minute) begin
          relay_to(1'b1);
          if (!slot_en[i].rpt_en && !slot_en[i].off_en) begin
            slot_en[i].off_en = 1'b1;
            change_flag = 1'b1;
          end
        end
        if (slot_en[i].off_en && off_min[i] == it.minute) begin
          relay_to(1'b0);
          if (!slot_en[i].rpt_en) begin
            slot_en[i].off_en = 1'b0;
            change_flag = 1'b1;
          end
        end
      end
      r.changed = change_flag;
      change_flag = 1'b0;
    end else begin
      if (it.mode == MODE_WRITE && it.slot < SLOTS) begin
        if (it.minute < DAY_MINUTES) begin
          on_min[si] = it.minute;
          change_flag = 1'b1;
        end
        if (it.off_minute < DAY_MINUTES) begin
          off_min[si] = it.off_minute;
          change_flag = 1'b1;
        end
        e = '{off_en: it.off_enable, on_en: it.on_enable, rpt_en: it.repeat_enable};
        if (e != slot_en[si]) change_flag = 1'b1;
        slot_en[si] = e;
      end else if (it.mode == MODE_MANUAL) begin
        relay_to(it.relay_cmd);
      end
      r.changed = change_flag;
    end
    r.relay_on = relay_now;
    return r;
  endfunction

  function automatic row_t row(tors_mode_t m, int s, int mn, int om, bit on, bit off,
                               bit rpt, bit cmd, bit known = 0, bit relay = 0,
                               bit chg = 0);
    row_t r;
    r.it = '0;
    r.it.mode = m;
    r.it.slot = SLOT_IDX_W'(s);
    r.it.minute = MIN_W'(mn);
    r.it.off_minute = MIN_W'(om);
    r.it.on_enable = on;
    r.it.off_enable = off;
    r.it.repeat_enable = rpt;
    r.it.relay_cmd = cmd;
    r.known = known;
    r.want = '{relay_on: relay, changed: chg};
    return r;
  endfunction

  function automatic void refill_pool();
    minute_pool[0] = 0;
    minute_pool[1] = DAY_MINUTES - 1;
    for (int i = 2; i < 8; i++) minute_pool[i] = $urandom_range(0, DAY_MINUTES - 1);
  endfunction

  function automatic logic [MIN_W-1:0] pool_minute();
    return MIN_W'(minute_pool[$urandom_range(0, 7)]);
  endfunction

  // Mostly slot writes and ticks that hit the stored minutes; a little noise
  function automatic tors_in_t random_item();
    tors_in_t it;
    int       k;
    it = tors_in_t'($urandom);
    k = $urandom_range(0, 99);
    if (k < 45) begin
      it.mode = MODE_TICK;
      if ($urandom_range(0, 4) != 0) it.minute = pool_minute();
    end else if (k < 82) begin
      it.mode = MODE_WRITE;
      if ($urandom_range(0, 7) != 0) it.slot = SLOT_IDX_W'($urandom_range(0, SLOTS - 1));
      if ($urandom_range(0, 6) != 0) it.minute = pool_minute();
      if ($urandom_range(0, 6) != 0) it.off_minute = pool_minute();
      if ($urandom_range(0, 2) != 0) it.repeat_enable = 1'b0;
    end else if (k < 96) begin
      it.mode = MODE_MANUAL;
    end else begin
      it.mode = MODE_NONE;
    end
    return it;
  endfunction

  function automatic int pick_gap(bit quiet);
    int k;
    if (quiet) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(tors_in_t it, int gap, bit known, tors_out_t want);
    tors_out_t got;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= it;
    do @(posedge clk); while (busy);
    got = relay_step(it);
    relay_results_due.push_back(known ? want : got);
  endtask

  initial begin
    row_t      plan[$];
    tors_out_t none;
    bit        quiet;
    none = '0;
    quiet = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      on_min[i] = '0;
      off_min[i] = '0;
      slot_en[i] = '0;
    end
    refill_pool();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    plan = '{
      row(MODE_TICK,   0,     0,    0, 0, 0, 0, 0, 1, 0, 0),
      row(MODE_NONE,   15, 2047, 2047, 1, 1, 1, 1, 1, 0, 0),
      row(MODE_MANUAL, 0,     0,    0, 0, 0, 0, 1, 1, 1, 1),
      row(MODE_MANUAL, 0,     0,    0, 0, 0, 0, 1, 1, 1, 1),
      row(MODE_TICK,   0,  2047,    0, 0, 0, 0, 0, 1, 1, 1),
      row(MODE_TICK,   0,     0,    0, 0, 0, 0, 0, 1, 1, 0),
      row(MODE_MANUAL, 0,     0,    0, 0, 0, 0, 0, 1, 0, 1),
      row(MODE_TICK,   0,     0,    0, 0, 0, 0, 0, 1, 0, 1),
      row(MODE_WRITE,  15, 2047, 2047, 1, 1, 1, 0, 1, 0, 0),
      row(MODE_WRITE,  SLOTS,  0,   0, 1, 1, 1, 0, 1, 0, 0),
      row(MODE_WRITE,  0,  1440, 1440, 0, 0, 0, 0, 1, 0, 0),
      row(MODE_WRITE,  0,   100,  200, 1, 0, 0, 0),
      row(MODE_WRITE,  1,  1439, 1439, 1, 0, 0, 0),
      row(MODE_WRITE,  2,     0, 1439, 1, 1, 1, 0),
      row(MODE_WRITE,  3,  2047,    0, 0, 1, 1, 0),
      row(MODE_TICK,   0,     0,    0, 0, 0, 0, 0),
      row(MODE_TICK,   0,   100,    0, 0, 0, 0, 0),
      row(MODE_TICK,   0,   200,    0, 0, 0, 0, 0),
      row(MODE_TICK,   0,  1439,    0, 0, 0, 0, 0),
      row(MODE_TICK,   0,  1439,    0, 0, 0, 0, 0),
      row(MODE_WRITE,  0,     0,    0, 0, 0, 0, 0),
      row(MODE_MANUAL, 0,     0,    0, 0, 0, 0, 1),
      row(MODE_TICK,   0,  2047,    0, 0, 0, 0, 0)
    };
    foreach (plan[i]) send_item(plan[i].it, pick_gap(1'b0), plan[i].known, plan[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n % 256 == 0) refill_pool();
      send_item(random_item(), pick_gap(quiet), 1'b0, none);
    end
    start <= 1'b0;

    while (relay_results_due.size() != 0) @(posedge clk);
    // hold on past the longest tick for any stray result
    repeat (SLOTS + 8) @(posedge clk);
    if (fails == 0) begin
      $display("time_of_day_relay_scheduler_tb: PASS");
    end else begin
      $display("time_of_day_relay_scheduler_tb: FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    tors_out_t due;
    if (!rst && done) begin
      if (relay_results_due.size() == 0) begin
        $error("result with no transaction outstanding");
        fails++;
      end else begin
        due = relay_results_due.pop_front();
        if (rsp.relay_on !== due.relay_on) begin
          $error("relay_on: expected %0b, got %0b", due.relay_on, rsp.relay_on);
          fails++;
        end
        if (rsp.changed !== due.changed) begin
          $error("changed: expected %0b, got %0b", due.changed, rsp.changed);
          fails++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("time_of_day_relay_scheduler_tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tors_pkg.sv
rtl/tors_slot_table.sv
rtl/tors_ctrl.sv
rtl/time_of_day_relay_scheduler.sv
test/time_of_day_relay_scheduler_tb.sv
